// ----- rtl/cls_pkg.sv -----
// Package for the clutch launch sequencer: beat types, codes and ramp constants.
package cls_pkg;

    localparam int unsigned POS_BITS = 16;

    // Mode codes
    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_LAUNCH = 2'd1;
    localparam logic [1:0] MODE_ERROR  = 2'd2;

    // Launch phase codes
    localparam logic [1:0] PH_HOLD   = 2'd0;
    localparam logic [1:0] PH_WAIT   = 2'd1;
    localparam logic [1:0] PH_RAMP   = 2'd2;
    localparam logic [1:0] PH_FINISH = 2'd3;

    // Config register indexes
    localparam logic [1:0] CFG_DEBOUNCE_MS      = 2'd0;
    localparam logic [1:0] CFG_LAUNCH_WAIT_MS   = 2'd1;
    localparam logic [1:0] CFG_ERROR_HOLD_MS    = 2'd2;
    localparam logic [1:0] CFG_ENGAGE_THRESHOLD = 2'd3;

    localparam logic [9:0]  DEBOUNCE_MS_RST      = 10'd50;
    localparam logic [15:0] LAUNCH_WAIT_MS_RST   = 16'd5000;
    localparam logic [15:0] ERROR_HOLD_MS_RST    = 16'd1000;
    localparam logic [15:0] ENGAGE_THRESHOLD_RST = 16'd19661;

    localparam logic [9:0]  DEB_MAX   = 10'd1023;
    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    // Q0.16 fractions, rounded to nearest
    localparam int unsigned FRAC_50 = ((50 << POS_BITS) + 50) / 100;
    localparam int unsigned FRAC_30 = ((30 << POS_BITS) + 50) / 100;
    localparam int unsigned FRAC_28 = ((28 << POS_BITS) + 50) / 100;
    localparam int unsigned FRAC_20 = ((20 << POS_BITS) + 50) / 100;
    localparam int unsigned FRAC_10 = ((10 << POS_BITS) + 50) / 100;

    localparam logic [15:0] TARGET_ENGAGE   = 16'(FRAC_50);
    localparam logic [15:0] TARGET_ERR_LOW  = 16'(FRAC_30);
    localparam logic [15:0] TARGET_RESET    = 16'(FRAC_10);

    // Release ramp breakpoints (ms) and values; values never rise
    localparam int unsigned RAMP_SEGMENTS = 4;
    localparam int unsigned RT0 = 0;
    localparam int unsigned RT1 = 2000;
    localparam int unsigned RT2 = 8000;
    localparam int unsigned RT3 = 10000;
    localparam int unsigned RT4 = 10001;
    localparam int unsigned RV0 = FRAC_50;
    localparam int unsigned RV1 = FRAC_28;
    localparam int unsigned RV2 = FRAC_20;
    localparam int unsigned RV3 = FRAC_10;
    localparam int unsigned RV4 = FRAC_10;

    localparam logic [15:0] RAMP_LAST_T = 16'(RT4);
    localparam logic [1:0]  SEG_LAST    = 2'(RAMP_SEGMENTS - 1);

    // Per segment: start value, end time, span, half span, drop per tick as quotient/remainder
    localparam logic [15:0] SEG_V0 [RAMP_SEGMENTS] =
        '{16'(RV0), 16'(RV1), 16'(RV2), 16'(RV3)};
    localparam logic [15:0] SEG_END [RAMP_SEGMENTS] =
        '{16'(RT1), 16'(RT2), 16'(RT3), 16'(RT4)};
    localparam logic [12:0] SEG_DEN [RAMP_SEGMENTS] =
        '{13'(RT1 - RT0), 13'(RT2 - RT1), 13'(RT3 - RT2), 13'(RT4 - RT3)};
    localparam logic [12:0] SEG_HALF [RAMP_SEGMENTS] =
        '{13'((RT1 - RT0) / 2), 13'((RT2 - RT1) / 2),
          13'((RT3 - RT2) / 2), 13'((RT4 - RT3) / 2)};
    localparam logic [15:0] SEG_QD [RAMP_SEGMENTS] =
        '{16'((RV0 - RV1) / (RT1 - RT0)), 16'((RV1 - RV2) / (RT2 - RT1)),
          16'((RV2 - RV3) / (RT3 - RT2)), 16'((RV3 - RV4) / (RT4 - RT3))};
    localparam logic [12:0] SEG_RD [RAMP_SEGMENTS] =
        '{13'((RV0 - RV1) % (RT1 - RT0)), 13'((RV1 - RV2) % (RT2 - RT1)),
          13'((RV2 - RV3) % (RT3 - RT2)), 13'((RV3 - RV4) % (RT4 - RT3))};

    typedef struct packed {
        logic        switch_level;
        logic [15:0] clutch_position;
        logic [15:0] lever_position;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] clutch_target;
        logic [1:0]  drive_mode;
        logic [1:0]  launch_phase;
    } t_out_beat;

endpackage

// ----- rtl/cls_stream_if.sv -----
// Valid/ready stream interface carrying one beat of a given payload type.
interface cls_stream_if #(parameter type T_DATA = logic);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/clutch_launch_sequencer.sv -----
// Clutch launch sequencer top level: mode machine, launch ramp and result register.
//
// One input beat per millisecond tick (switch level, clutch and lever position
// in Q0.16) yields one result beat (target, mode, launch phase). The block
// takes one beat per clock while the result register can take it: the whole
// update is combinational from the accepted beat and the state registers
// into a result register, and a new beat is accepted whenever that register
// is empty or being drained in the same cycle. The release ramp is
// interpolated with a running quotient/remainder accumulator per segment,
// so no divider sits in the path. Configuration is written through
// i_cfg_we/i_cfg_index/i_cfg_wdata and takes effect on the next beat;
// there is no clearing pass after reset. Error mode is left only by reset.
module clutch_launch_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_wdata,
    cls_stream_if.sink    i_in,
    cls_stream_if.source  o_out
);

    // Configuration
    logic [9:0]  r_debounce_ms;
    logic [15:0] r_launch_wait_ms;
    logic [15:0] r_error_hold_ms;
    logic [15:0] r_engage_threshold;

    // Mode machine state
    logic [1:0]  r_mode,         n_mode;
    logic [1:0]  r_phase,        n_phase;
    logic [9:0]  r_deb_count,    n_deb_count;
    logic        r_deb_armed,    n_deb_armed;
    logic [15:0] r_phase_timer,  n_phase_timer;
    logic [15:0] r_error_timer,  n_error_timer;
    logic [15:0] r_target,       n_target;

    // Ramp accumulator: drop so far = q, remainder r of (drop*dt + span/2) / span
    logic [1:0]  r_seg,          n_seg;
    logic [15:0] r_ramp_q,       n_ramp_q;
    logic [12:0] r_ramp_r,       n_ramp_r;

    // Result register
    logic             r_out_valid;
    cls_pkg::t_out_beat r_out, n_out;

    logic        in_fire;
    logic        sw;
    logic [15:0] clutch;
    logic [15:0] lever;
    logic        deb_active;
    logic [9:0]  deb_cnt_inc;
    logic        deb_trip;
    logic [15:0] ramp_val;
    logic [1:0]  adv_seg;
    logic [13:0] adv_acc;
    logic [15:0] adv_q;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v < cls_pkg::TIMER_MAX) ? v + 16'd1 : v;
    endfunction

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign sw     = i_in.data.switch_level;
    assign clutch = i_in.data.clutch_position;
    assign lever  = i_in.data.lever_position;

    // Debounce: manual waits for the switch set, launch for it released
    assign deb_active  = (r_mode == cls_pkg::MODE_MANUAL) ? sw : !sw;
    assign deb_cnt_inc = (r_deb_count < cls_pkg::DEB_MAX) ? r_deb_count + 10'd1 : r_deb_count;
    assign deb_trip    = deb_active && r_deb_armed && (deb_cnt_inc >= r_debounce_ms);

    assign ramp_val = cls_pkg::SEG_V0[r_seg] - r_ramp_q;

    // Next ramp accumulator value for t+1: restart at dt=1 of the next segment
    // when t is the current segment's end, else add one tick's drop.
    always_comb begin
        if (r_phase_timer == cls_pkg::SEG_END[r_seg] && r_seg != cls_pkg::SEG_LAST) begin
            adv_seg = r_seg + 2'd1;
            adv_acc = {1'b0, cls_pkg::SEG_HALF[adv_seg]} + {1'b0, cls_pkg::SEG_RD[adv_seg]};
            adv_q   = cls_pkg::SEG_QD[adv_seg];
        end else begin
            adv_seg = r_seg;
            adv_acc = {1'b0, r_ramp_r} + {1'b0, cls_pkg::SEG_RD[r_seg]};
            adv_q   = r_ramp_q + cls_pkg::SEG_QD[r_seg];
        end
    end

    always_comb begin
        n_mode        = r_mode;
        n_phase       = r_phase;
        n_deb_count   = r_deb_count;
        n_deb_armed   = r_deb_armed;
        n_phase_timer = r_phase_timer;
        n_error_timer = r_error_timer;
        n_target      = r_target;
        n_seg         = r_seg;
        n_ramp_q      = r_ramp_q;
        n_ramp_r      = r_ramp_r;

        // Debounce counter update (not used in error mode)
        if (r_mode != cls_pkg::MODE_ERROR) begin
            if (!deb_active) begin
                n_deb_count = '0;
                n_deb_armed = 1'b0;
            end else if (!r_deb_armed) begin
                n_deb_armed = 1'b1;
            end else begin
                n_deb_count = deb_cnt_inc;
            end
            if (deb_trip) begin
                n_deb_count = '0;
                n_deb_armed = 1'b0;
            end
        end

        case (r_mode)
            cls_pkg::MODE_MANUAL: begin
                n_target = lever;
                if (deb_trip) begin
                    n_mode        = cls_pkg::MODE_LAUNCH;
                    n_phase       = cls_pkg::PH_HOLD;
                    n_phase_timer = '0;
                end
            end
            cls_pkg::MODE_LAUNCH: begin
                if (deb_trip) begin
                    n_mode        = cls_pkg::MODE_ERROR;
                    n_target      = cls_pkg::TARGET_ENGAGE;
                    n_error_timer = '0;
                end else begin
                    case (r_phase)
                        cls_pkg::PH_HOLD: begin
                            if (clutch <= r_engage_threshold) begin
                                n_target = cls_pkg::TARGET_ENGAGE;
                            end else begin
                                n_phase       = cls_pkg::PH_WAIT;
                                n_phase_timer = '0;
                            end
                        end
                        cls_pkg::PH_WAIT: begin
                            n_phase_timer = sat_inc(r_phase_timer);
                            if (n_phase_timer > r_launch_wait_ms) begin
                                n_phase       = cls_pkg::PH_RAMP;
                                n_phase_timer = '0;
                                n_seg         = '0;
                                n_ramp_q      = '0;
                                n_ramp_r      = cls_pkg::SEG_HALF[0];
                            end
                        end
                        cls_pkg::PH_RAMP: begin
                            if (r_phase_timer <= cls_pkg::RAMP_LAST_T) begin
                                n_target      = (lever > ramp_val) ? lever : ramp_val;
                                n_phase_timer = sat_inc(r_phase_timer);
                                n_seg         = adv_seg;
                                if (adv_acc >= {1'b0, cls_pkg::SEG_DEN[adv_seg]}) begin
                                    n_ramp_r = 13'(adv_acc - {1'b0, cls_pkg::SEG_DEN[adv_seg]});
                                    n_ramp_q = adv_q + 16'd1;
                                end else begin
                                    n_ramp_r = adv_acc[12:0];
                                    n_ramp_q = adv_q;
                                end
                            end else begin
                                // past the last breakpoint: target held this tick
                                n_phase = cls_pkg::PH_FINISH;
                            end
                        end
                        default: begin
                            n_target = lever;
                        end
                    endcase
                end
            end
            default: begin
                n_error_timer = sat_inc(r_error_timer);
                if (n_error_timer > r_error_hold_ms) begin
                    n_target = cls_pkg::TARGET_ERR_LOW;
                end
            end
        endcase

        n_out.clutch_target = n_target;
        n_out.drive_mode    = n_mode;
        n_out.launch_phase  = (n_mode == cls_pkg::MODE_MANUAL) ? cls_pkg::PH_HOLD : n_phase;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms      <= cls_pkg::DEBOUNCE_MS_RST;
            r_launch_wait_ms   <= cls_pkg::LAUNCH_WAIT_MS_RST;
            r_error_hold_ms    <= cls_pkg::ERROR_HOLD_MS_RST;
            r_engage_threshold <= cls_pkg::ENGAGE_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cls_pkg::CFG_DEBOUNCE_MS:      r_debounce_ms      <= i_cfg_wdata[9:0];
                cls_pkg::CFG_LAUNCH_WAIT_MS:   r_launch_wait_ms   <= i_cfg_wdata;
                cls_pkg::CFG_ERROR_HOLD_MS:    r_error_hold_ms    <= i_cfg_wdata;
                cls_pkg::CFG_ENGAGE_THRESHOLD: r_engage_threshold <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // State update on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= cls_pkg::MODE_MANUAL;
            r_phase       <= cls_pkg::PH_HOLD;
            r_deb_count   <= '0;
            r_deb_armed   <= 1'b0;
            r_phase_timer <= '0;
            r_error_timer <= '0;
            r_target      <= cls_pkg::TARGET_RESET;
            r_seg         <= '0;
            r_ramp_q      <= '0;
            r_ramp_r      <= '0;
        end else if (in_fire) begin
            r_mode        <= n_mode;
            r_phase       <= n_phase;
            r_deb_count   <= n_deb_count;
            r_deb_armed   <= n_deb_armed;
            r_phase_timer <= n_phase_timer;
            r_error_timer <= n_error_timer;
            r_target      <= n_target;
            r_seg         <= n_seg;
            r_ramp_q      <= n_ramp_q;
            r_ramp_r      <= n_ramp_r;
        end
    end

    // Result register: refilled on accept, emptied when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- sim/clutch_launch_sequencer_test.sv -----
// Self-checking testbench for the clutch launch sequencer: directed and staged random ticks.
module clutch_launch_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog: cycles with no beat moving on either channel before giving up.
    // Worst correct case is the longest sender gap plus the longest stall plus
    // a config pause, so this is far beyond any legal quiet stretch.
    localparam int QUIET_LIMIT = 2000;
    localparam int REPORT_CAP  = 100;

    // Target levels in Q0.16, typed in by hand rather than taken from the package
    localparam logic [15:0] HALF_TRAVEL      = 16'd32768;   // 0.5
    localparam logic [15:0] ERROR_LOW_TARGET = 16'd19661;   // 0.3
    localparam logic [15:0] RESET_TARGET     = 16'd6554;    // 0.1

    // Release ramp breakpoints: time in ms and target in Q0.16
    localparam int RAMP_MS  [0:4] = '{0, 2000, 8000, 10000, 10001};
    localparam int RAMP_Q16 [0:4] = '{32768, 18350, 13107, 6554, 6554};

    // Opening table row: tick content plus an optional hand-typed target.
    // All rows run in manual mode at reset config, so mode and phase are 0.
    typedef struct packed {
        logic        sw;
        logic [15:0] clutch;
        logic [15:0] lever;
        logic        typed;
        logic [15:0] want_target;
    } t_opening_row;

    // Switch toggles stay far below the 50 ms debounce, so no row leaves manual
    t_opening_row opening_rows [18] = '{
        '{1'b0, 16'h0000, 16'h0000, 1'b1, 16'h0000},  // first beat after reset
        '{1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF},
        '{1'b1, 16'h0000, 16'h8000, 1'b1, 16'h8000},  // switch arms debounce
        '{1'b1, 16'hFFFF, 16'h7FFF, 1'b1, 16'h7FFF},
        '{1'b0, 16'h0000, 16'h0001, 1'b1, 16'h0001},  // low level clears it
        '{1'b1, 16'h4CCD, 16'hAAAA, 1'b1, 16'hAAAA},
        '{1'b0, 16'h4CCC, 16'h5555, 1'b1, 16'h5555},
        '{1'b1, 16'h8000, 16'hFFFE, 1'b0, 16'h0000},
        '{1'b1, 16'h7FFF, 16'h0000, 1'b0, 16'h0000},
        '{1'b1, 16'h0001, 16'h1234, 1'b1, 16'h1234},
        '{1'b1, 16'hFFFE, 16'hFEDC, 1'b0, 16'h0000},
        '{1'b0, 16'hFFFF, 16'h8001, 1'b0, 16'h0000},
        '{1'b1, 16'h5555, 16'h199A, 1'b1, 16'h199A},
        '{1'b0, 16'hAAAA, 16'h4CCD, 1'b0, 16'h0000},
        '{1'b1, 16'h0000, 16'hFFFF, 1'b1, 16'hFFFF},
        '{1'b1, 16'hFFFF, 16'h0000, 1'b1, 16'h0000},
        '{1'b0, 16'h8000, 16'h8000, 1'b0, 16'h0000},
        '{1'b0, 16'h0000, 16'h0000, 1'b1, 16'h0000}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;

    cls_stream_if #(.T_DATA(cls_pkg::t_in_beat))  tick_ch ();
    cls_stream_if #(.T_DATA(cls_pkg::t_out_beat)) target_ch ();

    // Sequencer state as this bench predicts it
    logic [1:0]  mode_q;
    logic [1:0]  phase_q;
    logic [9:0]  deb_cnt;
    logic        deb_armed;
    logic [15:0] phase_ms;
    logic [15:0] error_ms;
    logic [15:0] target_q;

    // Config mirror
    logic [9:0]  cfg_debounce;
    logic [15:0] cfg_wait;
    logic [15:0] cfg_hold;
    logic [15:0] cfg_thresh;

    cls_pkg::t_out_beat expected_beats [$];

    // Idling knobs, flipped per stage
    logic        gaps_on;
    logic        stalls_on;

    int          mismatch_count;
    int          results_checked;
    int          cfg_writes;
    int          ticks_by_mode [0:2];
    int          ramp_ticks;

    clutch_launch_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (tick_ch),
        .o_out       (target_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [15:0] bump_ms(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // True on the tick where the active level has been held long enough.
    // First active tick only arms; later ones count up, saturating at 1023.
    function automatic logic level_held(input logic active);
        if (!active) begin
            deb_cnt   = '0;
            deb_armed = 1'b0;
            return 1'b0;
        end
        if (!deb_armed) begin
            deb_armed = 1'b1;
            return 1'b0;
        end
        if (deb_cnt != 10'd1023)
            deb_cnt = deb_cnt + 10'd1;
        return deb_cnt >= cfg_debounce;
    endfunction

    function automatic cls_pkg::t_out_beat advance_sequencer(input cls_pkg::t_in_beat b);
        cls_pkg::t_out_beat r;
        longint    num;
        longint    mag;
        longint    span;
        logic      hit;
        hit = 1'b0;
        case (mode_q)
            cls_pkg::MODE_MANUAL: begin
                // target follows the lever even on the tick that trips launch
                target_q = b.lever_position;
                if (level_held(b.switch_level)) begin
                    mode_q    = cls_pkg::MODE_LAUNCH;
                    phase_q   = cls_pkg::PH_HOLD;
                    phase_ms  = '0;
                    deb_cnt   = '0;
                    deb_armed = 1'b0;
                end
            end
            cls_pkg::MODE_LAUNCH: begin
                if (level_held(!b.switch_level)) begin
                    // switch dropped for the debounce time: latch error,
                    // phase logic skipped on this tick
                    mode_q    = cls_pkg::MODE_ERROR;
                    deb_cnt   = '0;
                    deb_armed = 1'b0;
                    target_q  = HALF_TRAVEL;
                    error_ms  = '0;
                end else begin
                    case (phase_q)
                        cls_pkg::PH_HOLD: begin
                            if (b.clutch_position <= cfg_thresh) begin
                                target_q = HALF_TRAVEL;
                            end else begin
                                phase_q  = cls_pkg::PH_WAIT;
                                phase_ms = '0;
                            end
                        end
                        cls_pkg::PH_WAIT: begin
                            phase_ms = bump_ms(phase_ms);
                            if (phase_ms > cfg_wait) begin
                                phase_q  = cls_pkg::PH_RAMP;
                                phase_ms = '0;
                            end
                        end
                        cls_pkg::PH_RAMP: begin
                            // first segment whose span holds the elapsed time wins,
                            // so a shared breakpoint belongs to the earlier one
                            for (int seg = 0; seg < cls_pkg::RAMP_SEGMENTS && !hit; seg++) begin
                                if (int'(phase_ms) >= RAMP_MS[seg] &&
                                    int'(phase_ms) <= RAMP_MS[seg + 1]) begin
                                    hit  = 1'b1;
                                    span = RAMP_MS[seg + 1] - RAMP_MS[seg];
                                    num  = (longint'(RAMP_Q16[seg + 1]) - RAMP_Q16[seg]) *
                                           (longint'(phase_ms) - RAMP_MS[seg]);
                                    // round half away from zero
                                    mag  = (((num < 0) ? -num : num) + span / 2) / span;
                                    num  = RAMP_Q16[seg] + ((num < 0) ? -mag : mag);
                                    target_q = (b.lever_position > 16'(num)) ?
                                               b.lever_position : 16'(num);
                                    phase_ms = bump_ms(phase_ms);
                                end
                            end
                            // past the last point: finish, target kept this tick
                            if (!hit)
                                phase_q = cls_pkg::PH_FINISH;
                        end
                        default: target_q = b.lever_position;
                    endcase
                end
            end
            default: begin
                error_ms = bump_ms(error_ms);
                if (error_ms > cfg_hold)
                    target_q = ERROR_LOW_TARGET;
            end
        endcase
        r.clutch_target = target_q;
        r.drive_mode    = mode_q;
        r.launch_phase  = (mode_q == cls_pkg::MODE_MANUAL) ? cls_pkg::PH_HOLD : phase_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    function automatic logic [15:0] any_position();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Called at a clock edge; leaves valid high so back-to-back beats
    // need no extra NBA on valid.
    task automatic send_tick(input logic sw, input logic [15:0] clutch,
                             input logic [15:0] lever, input logic typed = 1'b0,
                             input logic [15:0] typed_target = '0);
        cls_pkg::t_in_beat  b;
        cls_pkg::t_out_beat predicted;
        b.switch_level    = sw;
        b.clutch_position = clutch;
        b.lever_position  = lever;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= b;
        do @(posedge i_clk); while (tick_ch.ready !== 1'b1);
        predicted = advance_sequencer(b);
        ticks_by_mode[mode_q]++;
        if (mode_q == cls_pkg::MODE_LAUNCH && phase_q == cls_pkg::PH_RAMP)
            ramp_ticks++;
        if (typed) begin
            predicted.clutch_target = typed_target;
            predicted.drive_mode    = cls_pkg::MODE_MANUAL;
            predicted.launch_phase  = cls_pkg::PH_HOLD;
        end
        expected_beats.push_back(predicted);
    endtask

    task automatic random_ticks(input int count, input int low_pct);
        repeat (count)
            send_tick($urandom_range(0, 99) >= low_pct, any_position(), any_position());
    endtask

    // Config is only touched with the sequencer drained and its last result taken.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        tick_ch.valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
        case (idx)
            cls_pkg::CFG_DEBOUNCE_MS:    cfg_debounce = val[9:0];
            cls_pkg::CFG_LAUNCH_WAIT_MS: cfg_wait     = val;
            cls_pkg::CFG_ERROR_HOLD_MS:  cfg_hold     = val;
            default:                     cfg_thresh   = val;
        endcase
    endtask

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls and in-order compare
    // ------------------------------------------------------------------

    initial begin : result_checker
        int                 stall_left;
        cls_pkg::t_out_beat want;
        cls_pkg::t_out_beat got;
        stall_left = 0;
        target_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && target_ch.valid === 1'b1 && target_ch.ready === 1'b1) begin
                got = target_ch.data;
                results_checked++;
                if (expected_beats.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP)
                        $display({"%0t: result beat with nothing expected: expected none, ",
                                  "actual target %0d mode %0d phase %0d"},
                                 $time, got.clutch_target, got.drive_mode, got.launch_phase);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.clutch_target !== want.clutch_target)
                        report_mismatch("clutch_target", want.clutch_target, got.clutch_target);
                    if (got.drive_mode !== want.drive_mode)
                        report_mismatch("drive_mode", want.drive_mode, got.drive_mode);
                    if (got.launch_phase !== want.launch_phase)
                        report_mismatch("launch_phase", want.launch_phase, got.launch_phase);
                end
            end
            // exactly one NBA on ready per edge
            if (stall_left > 0) begin
                stall_left--;
                target_ch.ready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 14);
                target_ch.ready <= 1'b0;
            end else begin
                target_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on beat movement
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) ||
                (target_ch.valid === 1'b1 && target_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles, %0d results still expected",
                 $time, quiet, expected_beats.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus. Launch is entered once and error is terminal (reset only),
    // so the run walks manual -> launch phases -> error in that order.
    // ------------------------------------------------------------------

    initial begin : stimulus
        int          n;
        int          run;
        logic        lvl;
        logic [15:0] lever;

        mode_q       = cls_pkg::MODE_MANUAL;
        phase_q      = cls_pkg::PH_HOLD;
        deb_cnt      = '0;
        deb_armed    = 1'b0;
        phase_ms     = '0;
        error_ms     = '0;
        target_q     = RESET_TARGET;
        cfg_debounce = 10'd50;
        cfg_wait     = 16'd5000;
        cfg_hold     = 16'd1000;
        cfg_thresh   = 16'd19661;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= cls_pkg::CFG_DEBOUNCE_MS;
        i_cfg_wdata   <= '0;
        tick_ch.valid <= 1'b0;
        tick_ch.data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Opening table at reset config, all in manual
        foreach (opening_rows[i])
            send_tick(opening_rows[i].sw, opening_rows[i].clutch, opening_rows[i].lever,
                      opening_rows[i].typed, opening_rows[i].want_target);

        // Manual with every register at its top value; switch highs in long
        // runs that still stay short of a 1023 ms debounce
        write_reg(cls_pkg::CFG_DEBOUNCE_MS, 16'd1023);
        write_reg(cls_pkg::CFG_LAUNCH_WAIT_MS, 16'hFFFF);
        write_reg(cls_pkg::CFG_ERROR_HOLD_MS, 16'hFFFF);
        write_reg(cls_pkg::CFG_ENGAGE_THRESHOLD, 16'hFFFF);
        n = 0;
        while (n < 150) begin
            lvl = 1'($urandom_range(0, 1));
            run = lvl ? $urandom_range(1, 300) : $urandom_range(1, 20);
            repeat (run) begin
                send_tick(lvl, any_position(), any_position());
                n++;
            end
        end

        // Zero debounce: any two highs in a row trip. Isolated highs first,
        // each preceded by a low so a leftover armed state cannot trip.
        write_reg(cls_pkg::CFG_DEBOUNCE_MS, 16'd0);
        repeat (40) begin
            repeat ($urandom_range(1, 3)) send_tick(1'b0, any_position(), any_position());
            send_tick(1'b1, any_position(), any_position());
        end
        while (mode_q == cls_pkg::MODE_MANUAL)
            send_tick(1'b1, any_position(), any_position());

        // Launch, hold phase. Threshold at max: no clutch value engages.
        // A stretch with no idling on either side.
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        write_reg(cls_pkg::CFG_DEBOUNCE_MS, 16'd1023);
        random_ticks(60, 30);
        write_reg(cls_pkg::CFG_ENGAGE_THRESHOLD, 16'd0);
        repeat (8) send_tick(1'b1, 16'h0000, any_position());
        // threshold boundary: equal holds, one above engages
        write_reg(cls_pkg::CFG_ENGAGE_THRESHOLD, 16'd40000);
        repeat (2) send_tick(1'b1, 16'd40000, any_position());
        repeat (20)
            send_tick($urandom_range(0, 3) != 0, 16'($urandom_range(0, 40000)), any_position());
        send_tick(1'b1, 16'd40001, any_position());

        // Wait phase: endless at max wait, then cut to a boundary the
        // running timer reaches shortly
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        random_ticks(100, 20);
        write_reg(cls_pkg::CFG_LAUNCH_WAIT_MS, 16'd120);
        while (mode_q == cls_pkg::MODE_LAUNCH && phase_q == cls_pkg::PH_WAIT)
            random_ticks(1, 20);

        // Start of the release ramp. The whole ramp spans ten thousand ticks,
        // so only the top of its first segment is walked. Lever mostly under
        // the ramp so the curve shows, sometimes above it so the lever wins.
        repeat (200) begin
            case ($urandom_range(0, 19))
                0:       lever = 16'($urandom);
                1, 2:    lever = 16'($urandom_range(6000, 33000));
                default: lever = 16'($urandom_range(0, 6000));
            endcase
            send_tick($urandom_range(0, 9) != 0, any_position(), lever);
        end

        // Short debounce with low glitches of at most five ticks before
        // the real drop.
        write_reg(cls_pkg::CFG_DEBOUNCE_MS, 16'd5);
        write_reg(cls_pkg::CFG_ERROR_HOLD_MS, 16'hFFFF);
        repeat (30) begin
            repeat ($urandom_range(1, 10)) send_tick(1'b1, any_position(), any_position());
            repeat ($urandom_range(1, 5)) send_tick(1'b0, any_position(), any_position());
        end
        while (mode_q == cls_pkg::MODE_LAUNCH)
            send_tick(1'b0, any_position(), any_position());

        // Error: 0.5 under a max hold, then a hold the timer passes soon
        random_ticks(60, 50);
        write_reg(cls_pkg::CFG_ERROR_HOLD_MS, 16'd80);
        random_ticks(40, 50);

        // Last part without idling
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        write_reg(cls_pkg::CFG_ERROR_HOLD_MS, 16'd0);
        write_reg(cls_pkg::CFG_DEBOUNCE_MS, 16'd1);
        random_ticks(150, 50);

        tick_ch.valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("summary: %0d ticks: %0d manual, %0d launch (%0d on the release ramp), %0d error",
                 ticks_by_mode[0] + ticks_by_mode[1] + ticks_by_mode[2], ticks_by_mode[0],
                 ticks_by_mode[1], ramp_ticks, ticks_by_mode[2]);
        $display("summary: %0d result beats checked, %0d config writes, %0d field mismatches",
                 results_checked, cfg_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- clutch_launch_sequencer.f -----
rtl/cls_pkg.sv
rtl/cls_stream_if.sv
rtl/clutch_launch_sequencer.sv
sim/clutch_launch_sequencer_test.sv
